### hw/rtl/swsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package swsd_pkg;

   localparam int WINDOW_DEPTH = 8;
   localparam int POS_W = $clog2(WINDOW_DEPTH);
   localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
   // One extra bit so a full window of extreme samples cannot overflow.
   localparam int SUM_W = 19 + POS_W + 1;
   localparam int CNT_W = $clog2(SUM_W + 1);

   typedef logic signed [21:0] ext_type;

   localparam logic [1:0] CMD_START    = 2'd0;
   localparam logic [1:0] CMD_SAMPLE   = 2'd1;
   localparam logic [1:0] CMD_TICK     = 2'd2;
   localparam logic [1:0] CMD_RESERVED = 2'd3;

   localparam logic [1:0] EV_IGNORED  = 2'd0;
   localparam logic [1:0] EV_SETTLING = 2'd1;
   localparam logic [1:0] EV_SETTLED  = 2'd2;
   localparam logic [1:0] EV_CUP      = 2'd3;

   localparam logic [2:0] VD_NONE      = 3'd0;
   localparam logic [2:0] VD_LEARN     = 3'd1;
   localparam logic [2:0] VD_NO_SCALE  = 3'd2;
   localparam logic [2:0] VD_LOW_FLOW  = 3'd3;
   localparam logic [2:0] VD_UNREASON  = 3'd4;
   localparam logic [2:0] VD_CUP_DROP  = 3'd5;
   localparam logic [2:0] VD_DRIP_BIG  = 3'd6;

   localparam logic [2:0] REG_STABLE  = 3'd0;
   localparam logic [2:0] REG_CLEAN   = 3'd1;
   localparam logic [2:0] REG_SILENCE = 3'd2;
   localparam logic [2:0] REG_TIMEOUT = 3'd3;
   localparam logic [2:0] REG_CUPDROP = 3'd4;
   localparam logic [2:0] REG_MAXDRIP = 3'd5;
   localparam logic [2:0] REG_DRIFT   = 3'd6;
   localparam logic [2:0] REG_MARGIN  = 3'd7;

   localparam logic [2:0] K_IGN     = 3'd0;
   localparam logic [2:0] K_START   = 3'd1;
   localparam logic [2:0] K_TIMEOUT = 3'd2;
   localparam logic [2:0] K_SAMPLE  = 3'd3;
   localparam logic [2:0] K_TICK    = 3'd4;
   localparam logic [2:0] K_CUP     = 3'd5;

   localparam int STILL_DELTA_CG = 10;
   localparam int BELOW_STOP_CG = 50;
   localparam int MIN_FLOW_CGPS = 50;
   localparam int LIMIT_CG = 2000;

   function automatic ext_type sx19(input logic [18:0] v);
      return ext_type'({{3{v[18]}}, v});
   endfunction

   function automatic ext_type zx(input logic [17:0] v);
      return ext_type'({4'd0, v});
   endfunction

endpackage
`default_nettype wire

### hw/rtl/scale_weight_settling_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// Scale weight settling detector.
// Input beats arrive on req_* (command in req_tuser), results leave on rsp_*
// (event code in rsp_tuser); every accepted input beat yields exactly one
// result beat. Registers are written on csr_* (index, data) at any time; the
// port is always ready, and writes are meant to happen while the block is idle.
// A start beat records the stop conditions and opens settling. Weight samples
// update the rolling window, which lives in an 8-entry synchronous RAM that is
// read one cycle and written back the next. Samples, ticks and timeouts then run a
// bit-serial divider for the window average, one quotient bit per cycle.
// Start and ignored beats go from acceptance straight to the decision step;
// ticks and timeouts pass through the 23-step divider first, and samples the
// window update before it. The block handles one beat at a time and accepts
// no new beat until the last one is committed to the output register.
// The result register holds its beat while rsp_tready is low; the block may
// accept and work the next beat meanwhile, but holds its final step until the
// output register is free.
// Reset (synchronous, active high) clears the control state and loads the
// register defaults; settling is inactive after reset.
module scale_weight_settling_detector (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // now_ms[31:0], weight_cg[50:32], stop_weight_cg[69:51],
   // stop_flow_cgps[83:70], target_weight_cg[101:84], scale_physical[102]
   input  wire logic [103:0]  req_tdata,
   // command[1:0]
   input  wire logic [1:0]    req_tuser,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // verdict[2:0], final_weight_cg[21:3], drip_cg[41:22], overshoot_cg[61:42],
   // flow_at_stop_cgps[75:62], rolling_avg_cg[94:76], settling_on[95]
   output logic [95:0]        rsp_tdata,
   // event_res[1:0]
   output logic [1:0]         rsp_tuser,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [2:0]    csr_index,
   input  wire logic [16:0]   csr_wdata
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_UPD  = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_DEC  = 2'd3;

   localparam int PW = swsd_pkg::POS_W;
   localparam int FW = swsd_pkg::FILL_W;
   localparam int SW = swsd_pkg::SUM_W;
   localparam int CW = swsd_pkg::CNT_W;

   // Configuration.
   logic [15:0] stable_ff, clean_ms_ff, silence_ff, timeout_ff;
   logic [16:0] cupdrop_ff, maxdrip_ff;
   logic [13:0] drift_ff, margin_ff;

   // Control and settling state.
   logic [1:0]  state_ff, state_in;
   logic [2:0]  kind_ff, kind_in;
   logic        active_ff, active_in;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [18:0] held_ff, held_in, peak_ff, peak_in, sref_ff, sref_in;
   logic [18:0] prev_ff, prev_in, clean_ff, clean_in;
   logic [31:0] lmove_ff, lmove_in, ass_ff, ass_in, start_ff, start_in;
   logic [31:0] still_ff, still_in;
   logic [18:0] stopw_ff, stopw_in;
   logic [13:0] sflow_ff, sflow_in;
   logic [17:0] target_ff, target_in;

   // Latched input beat.
   logic [31:0] now_ff;
   logic [18:0] w_ff;
   logic        phys_ff;

   // Divider.
   logic [CW-1:0] dcnt_ff, dcnt_in;
   logic [FW-1:0] drem_ff, drem_in;
   logic [SW-1:0] dquo_ff, dquo_in;
   logic          dneg_ff, dneg_in;

   // Window RAM.
   logic [18:0] win_mem [swsd_pkg::WINDOW_DEPTH];
   logic [18:0] win_rd_ff;
   logic        win_re, win_we;
   logic [18:0] win_wd;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [95:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_ev_ff, rsp_ev_in;

   logic req_fire;
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_ev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= 16'd1000;
         clean_ms_ff <= 16'd500;
         silence_ff <= 16'd2000;
         timeout_ff <= 16'd10000;
         cupdrop_ff <= 17'd2000;
         maxdrip_ff <= 17'd1000;
         drift_ff <= 14'd10;
         margin_ff <= 14'd30;
      end else if (csr_valid) begin
         unique case (csr_index)
            swsd_pkg::REG_STABLE:  stable_ff <= csr_wdata[15:0];
            swsd_pkg::REG_CLEAN:   clean_ms_ff <= csr_wdata[15:0];
            swsd_pkg::REG_SILENCE: silence_ff <= csr_wdata[15:0];
            swsd_pkg::REG_TIMEOUT: timeout_ff <= csr_wdata[15:0];
            swsd_pkg::REG_CUPDROP: cupdrop_ff <= csr_wdata;
            swsd_pkg::REG_MAXDRIP: maxdrip_ff <= csr_wdata;
            swsd_pkg::REG_DRIFT:   drift_ff <= csr_wdata[13:0];
            swsd_pkg::REG_MARGIN:  margin_ff <= csr_wdata[13:0];
            default: ;
         endcase
      end
   end

   // Window RAM: read the slot about to be overwritten, write it back later.
   always_ff @(posedge clock) begin
      if (win_re) begin
         win_rd_ff <= win_mem[pos_ff];
      end
      if (win_we) begin
         win_mem[pos_ff] <= win_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         now_ff <= req_tdata[31:0];
         w_ff <= req_tdata[50:32];
         phys_ff <= req_tdata[102];
      end
   end

   // Datapath helpers.
   swsd_pkg::ext_type avg_x, w_x, held_x, peak_x, stopw_x, clean_x, hw_x;
   swsd_pkg::ext_type drip_x, over_x, drift_x, above_ref;
   logic [18:0] avg, hw_n;
   logic [18:0] q19;
   logic [FW:0] dr2;
   logic        dbit;
   logic        done, stable_ok, below, above;
   logic [31:0] still_t, held_t, ass_t, tmo_t;
   logic [2:0]  vd;
   logic [1:0]  ev;

   always_comb begin
      q19 = dquo_ff[18:0];
      if (fill_ff == '0) begin
         avg = '0;
      end else if (dneg_ff) begin
         avg = 19'(-q19);
      end else begin
         avg = q19;
      end
   end

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      active_in = active_ff;
      sum_in = sum_ff;
      pos_in = pos_ff;
      fill_in = fill_ff;
      held_in = held_ff;
      peak_in = peak_ff;
      sref_in = sref_ff;
      prev_in = prev_ff;
      clean_in = clean_ff;
      lmove_in = lmove_ff;
      ass_in = ass_ff;
      start_in = start_ff;
      still_in = still_ff;
      stopw_in = stopw_ff;
      sflow_in = sflow_ff;
      target_in = target_ff;
      dcnt_in = dcnt_ff;
      drem_in = drem_ff;
      dquo_in = dquo_ff;
      dneg_in = dneg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_ev_in = rsp_ev_ff;
      win_re = 1'b0;
      win_we = 1'b0;
      win_wd = w_ff;

      w_x = swsd_pkg::sx19(w_ff);
      avg_x = swsd_pkg::sx19(avg);
      held_x = swsd_pkg::sx19(held_ff);
      peak_x = swsd_pkg::sx19(peak_ff);
      stopw_x = swsd_pkg::sx19(stopw_ff);
      clean_x = swsd_pkg::sx19(clean_ff);
      hw_x = '0;
      drip_x = '0;
      over_x = '0;
      above_ref = avg_x + swsd_pkg::zx({4'd0, margin_ff});
      drift_x = avg_x - swsd_pkg::sx19(prev_ff);
      if (drift_x < 0) begin
         drift_x = -drift_x;
      end
      tmo_t = req_tdata[31:0] - start_ff;
      still_t = now_ff - lmove_ff;
      ass_t = (ass_ff == '0) ? now_ff : ass_ff;
      held_t = now_ff - ass_t;
      stable_ok = 1'b0;
      below = 1'b0;
      above = 1'b0;
      done = 1'b0;
      hw_n = held_ff;
      ev = swsd_pkg::EV_SETTLING;
      vd = swsd_pkg::VD_NONE;
      dr2 = {drem_ff, dquo_ff[SW-1]};
      dbit = (dr2 >= {1'b0, fill_ff});

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               win_re = 1'b1;
               if (req_tuser == swsd_pkg::CMD_START) begin
                  kind_in = swsd_pkg::K_START;
                  state_in = S_DEC;
                  held_in = req_tdata[50:32];
                  stopw_in = req_tdata[69:51];
                  sflow_in = req_tdata[83:70];
                  target_in = req_tdata[101:84];
                  sref_in = req_tdata[50:32];
                  peak_in = req_tdata[50:32];
                  prev_in = req_tdata[50:32];
                  lmove_in = req_tdata[31:0];
                  start_in = req_tdata[31:0];
                  sum_in = '0;
                  pos_in = '0;
                  fill_in = '0;
                  clean_in = '0;
                  ass_in = '0;
                  active_in = 1'b1;
               end else if (!active_ff || (req_tuser != swsd_pkg::CMD_SAMPLE &&
                                           req_tuser != swsd_pkg::CMD_TICK)) begin
                  kind_in = swsd_pkg::K_IGN;
                  state_in = S_DEC;
               end else if (tmo_t >= {16'd0, timeout_ff}) begin
                  kind_in = swsd_pkg::K_TIMEOUT;
                  state_in = S_DIV;
               end else if (req_tuser == swsd_pkg::CMD_SAMPLE) begin
                  kind_in = swsd_pkg::K_SAMPLE;
                  state_in = S_UPD;
               end else begin
                  kind_in = swsd_pkg::K_TICK;
                  state_in = S_DIV;
               end
               dcnt_in = '0;
            end
         end
         S_UPD: begin
            // Read-modify-write of the window slot at the write pointer, skipped on a cup drop.
            if (w_x > peak_x) begin
               peak_in = w_ff;
               peak_x = w_x;
            end
            state_in = S_DIV;
            if (w_x < peak_x - swsd_pkg::ext_type'({5'd0, cupdrop_ff})) begin
               kind_in = swsd_pkg::K_CUP;
            end else begin
               held_in = w_ff;
               win_we = 1'b1;
               if (fill_ff >= FW'(swsd_pkg::WINDOW_DEPTH)) begin
                  sum_in = sum_ff - SW'(signed'(win_rd_ff)) + SW'(signed'(w_ff));
               end else begin
                  sum_in = sum_ff + SW'(signed'(w_ff));
                  fill_in = fill_ff + 1'b1;
               end
               pos_in = (pos_ff == PW'(swsd_pkg::WINDOW_DEPTH - 1)) ? '0 : pos_ff + 1'b1;
               if ((w_x - swsd_pkg::sx19(sref_ff) >= swsd_pkg::STILL_DELTA_CG) ||
                   (swsd_pkg::sx19(sref_ff) - w_x >= swsd_pkg::STILL_DELTA_CG)) begin
                  sref_in = w_ff;
                  lmove_in = now_ff;
                  still_in = '0;
               end else begin
                  still_in = still_t;
               end
            end
         end
         S_DIV: begin
            // Restoring division of |sum| by the fill count, one bit a cycle.
            if (dcnt_ff == '0) begin
               dneg_in = sum_ff[SW-1];
               dquo_in = sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);
               drem_in = '0;
               dcnt_in = CW'(SW);
            end else begin
               drem_in = dbit ? FW'(dr2 - {1'b0, fill_ff}) : FW'(dr2);
               dquo_in = {dquo_ff[SW-2:0], dbit};
               dcnt_in = dcnt_ff - 1'b1;
               if (dcnt_ff == CW'(1)) begin
                  state_in = S_DEC;
               end
            end
         end
         S_DEC: begin
            case (kind_ff)
               swsd_pkg::K_TIMEOUT: done = 1'b1;
               swsd_pkg::K_CUP: begin
                  if (clean_x > 0 && (stopw_x <= 0 ||
                      clean_x - stopw_x <= swsd_pkg::ext_type'({5'd0, maxdrip_ff}))) begin
                     hw_n = clean_ff;
                  end else if (clean_x > 0 && stopw_x > 0) begin
                     hw_n = stopw_ff;
                  end else if (stopw_x > 0 && held_x < stopw_x) begin
                     hw_n = stopw_ff;
                  end
                  ev = swsd_pkg::EV_CUP;
                  vd = swsd_pkg::VD_CUP_DROP;
               end
               swsd_pkg::K_SAMPLE: begin
                  prev_in = avg;
                  if (still_ff >= {16'd0, stable_ff}) begin
                     done = 1'b1;
                  end else if (fill_ff >= FW'(swsd_pkg::WINDOW_DEPTH)) begin
                     below = (stopw_x > 0) && (avg_x < stopw_x - swsd_pkg::BELOW_STOP_CG);
                     above = w_x > above_ref;
                     stable_ok = (drift_x < swsd_pkg::ext_type'({8'd0, drift_ff})) &&
                                 !below && !above;
                     if (stable_ok) begin
                        ass_in = ass_t;
                        if (held_t >= {16'd0, clean_ms_ff}) begin
                           clean_in = avg;
                        end
                        if (held_t >= {16'd0, stable_ff}) begin
                           hw_n = avg;
                           done = 1'b1;
                        end
                     end else begin
                        ass_in = '0;
                     end
                  end
               end
               swsd_pkg::K_TICK: begin
                  if (still_t >= {16'd0, stable_ff}) begin
                     if (still_t >= {16'd0, silence_ff}) begin
                        done = 1'b1;
                     end else if (fill_ff != '0 && held_x > above_ref) begin
                        ass_in = '0;
                     end else begin
                        done = 1'b1;
                     end
                  end else if (ass_ff != '0 && (now_ff - ass_ff) >= {16'd0, stable_ff}) begin
                     if (held_x > above_ref) begin
                        ass_in = '0;
                     end else begin
                        clean_in = avg;
                        hw_n = avg;
                        done = 1'b1;
                     end
                  end
               end
               default: ;
            endcase

            hw_x = swsd_pkg::sx19(hw_n);
            drip_x = hw_x - stopw_x;
            over_x = hw_x - swsd_pkg::zx(target_ff);
            if (done) begin
               ev = swsd_pkg::EV_SETTLED;
               if (!phys_ff) begin
                  vd = swsd_pkg::VD_NO_SCALE;
               end else if (sflow_ff < 14'(swsd_pkg::MIN_FLOW_CGPS)) begin
                  vd = swsd_pkg::VD_LOW_FLOW;
               end else if (hw_x < 0 || over_x > swsd_pkg::LIMIT_CG ||
                            over_x < -swsd_pkg::LIMIT_CG) begin
                  vd = swsd_pkg::VD_UNREASON;
               end else if (hw_x < peak_x - swsd_pkg::ext_type'({5'd0, cupdrop_ff})) begin
                  vd = swsd_pkg::VD_CUP_DROP;
               end else if (drip_x > swsd_pkg::LIMIT_CG) begin
                  vd = swsd_pkg::VD_DRIP_BIG;
               end else begin
                  vd = swsd_pkg::VD_LEARN;
               end
            end

            // Commit only when the output register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = S_IDLE;
               rsp_valid_in = 1'b1;
               if (kind_ff == swsd_pkg::K_IGN) begin
                  rsp_ev_in = swsd_pkg::EV_IGNORED;
                  rsp_data_in = '0;
               end else begin
                  held_in = hw_n;
                  if (done || kind_ff == swsd_pkg::K_CUP) begin
                     active_in = 1'b0;
                  end
                  rsp_ev_in = ev;
                  rsp_data_in[2:0] = vd;
                  rsp_data_in[21:3] = hw_n;
                  rsp_data_in[41:22] = (ev == swsd_pkg::EV_SETTLING) ? '0 : drip_x[19:0];
                  rsp_data_in[61:42] = (ev == swsd_pkg::EV_SETTLING) ? '0 : over_x[19:0];
                  rsp_data_in[75:62] = sflow_ff;
                  rsp_data_in[94:76] = avg;
                  rsp_data_in[95] = (kind_ff == swsd_pkg::K_START) ||
                                    (!done && kind_ff != swsd_pkg::K_CUP);
               end
            end else begin
               // The decision is taken again next cycle, so the settling
               // state it reads must not move until the beat is committed.
               prev_in = prev_ff;
               ass_in = ass_ff;
               clean_in = clean_ff;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         active_ff <= 1'b0;
         sum_ff <= '0;
         pos_ff <= '0;
         fill_ff <= '0;
         held_ff <= '0;
         peak_ff <= '0;
         sref_ff <= '0;
         prev_ff <= '0;
         clean_ff <= '0;
         lmove_ff <= '0;
         ass_ff <= '0;
         start_ff <= '0;
         stopw_ff <= '0;
         sflow_ff <= '0;
         target_ff <= '0;
         dcnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         active_ff <= active_in;
         sum_ff <= sum_in;
         pos_ff <= pos_in;
         fill_ff <= fill_in;
         held_ff <= held_in;
         peak_ff <= peak_in;
         sref_ff <= sref_in;
         prev_ff <= prev_in;
         clean_ff <= clean_in;
         lmove_ff <= lmove_in;
         ass_ff <= ass_in;
         start_ff <= start_in;
         stopw_ff <= stopw_in;
         sflow_ff <= sflow_in;
         target_ff <= target_in;
         dcnt_ff <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      still_ff <= still_in;
      drem_ff <= drem_in;
      dquo_ff <= dquo_in;
      dneg_ff <= dneg_in;
      rsp_data_ff <= rsp_data_in;
      rsp_ev_ff <= rsp_ev_in;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(swsd_pkg::WINDOW_DEPTH))
      else $error("window fill count beyond depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != S_IDLE)
      else $error("block idle right after accepting a beat");

   a_result_from_decide: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DEC)
      else $error("result appeared outside the decision step");

   a_div_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && dcnt_ff == CW'(1)) |=> state_ff == S_DEC)
      else $error("divider did not hand over to the decision step");

endmodule
`default_nettype wire
